/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the fan duty controller, empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define FDCH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define FDCH_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define FDCH_ASSERT(lbl, prop, msg)

`define FDCH_NEVER(lbl, expr, msg)

`endif

`endif

/* rtl/core/fdch_pkg.sv */
// ----------------------------------------------------------------------------
// fdch_pkg
// Types and constants shared by the fan duty controller modules.
// ----------------------------------------------------------------------------
package fdch_pkg;

  localparam int TEMP_W      = 19;
  localparam int DEG_W       = 9;
  localparam int DUTY_W      = 10;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 10;
  localparam int DIV_NW      = 19;
  localparam int DIV_DW      = 10;
  localparam int DEG_RECIP_W = 18;
  localparam int DEG_SHIFT   = 27;
  localparam int DEG_PROD_W  = TEMP_W + DEG_RECIP_W;

  // 2^27 / 1000 rounded up; the shifted product is the exact quotient by 1000
  // for every 19-bit magnitude
  localparam logic [DEG_RECIP_W-1:0] DEG_RECIP = 18'd134218;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMP_LO    = 3'd0,
    REG_HYSTERESIS = 3'd1,
    REG_TEMP_HI    = 3'd2,
    REG_MIN_DUTY   = 3'd3,
    REG_MAX_DUTY   = 3'd4,
    REG_CURVE_EN   = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TMUL,
    ST_TCONV,
    ST_DECIDE,
    ST_CSTART,
    ST_CWAIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [7:0]        temp_lo;
    logic [5:0]        hysteresis;
    logic [7:0]        temp_hi;
    logic [DUTY_W-1:0] min_duty;
    logic [DUTY_W-1:0] max_duty;
    logic              curve_enable;
  } cfg_t;

  typedef struct packed {
    logic load_in;
    logic mul_load;
    logic div_start;
    logic t_load;
    logic dec_load;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic need_div;
    logic out_free;
  } sts_t;

endpackage

/* rtl/core/fdch_div.sv */
// ----------------------------------------------------------------------------
// fdch_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fdch_div #(
  parameter int NW = 19,
  parameter int DW = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic          done,
  output logic [NW-1:0] quot,
  output logic [DW-1:0] rem
);

  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem_r;
  logic [NW-1:0] quo_r;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;

  logic [DW:0]   shifted;
  logic [DW:0]   diff;
  logic          ge;
  logic [DW-1:0] rem_nxt;
  logic [NW-1:0] quo_nxt;

  always_comb begin
    shifted = {rem_r, quo_r[NW-1]};
    diff    = shifted - {1'b0, den_r};
    ge      = (shifted >= {1'b0, den_r});
    rem_nxt = ge ? diff[DW-1:0] : shifted[DW-1:0];
    quo_nxt = {quo_r[NW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule

/* rtl/core/fdch_datapath.sv */
// ----------------------------------------------------------------------------
// fdch_datapath
// Degree conversion, threshold decisions, curve interpolation and result
// register of the fan duty controller.
// ----------------------------------------------------------------------------
module fdch_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  fdch_pkg::cfg_t                       cfg,
  input  fdch_pkg::cmd_t                       cmd,
  output fdch_pkg::sts_t                       sts,
  input  logic signed [fdch_pkg::TEMP_W-1:0]   in_temp_milli,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic        [fdch_pkg::DUTY_W-1:0]   out_duty,
  output logic signed [fdch_pkg::DEG_W-1:0]    out_temp_degrees
);

  import fdch_pkg::*;

  logic [TEMP_W-1:0]     temp_r;
  logic [DEG_PROD_W-1:0] deg_prod_r;
  logic [DEG_W-1:0]      t_r;
  logic [DUTY_W-1:0]     dec_duty_r;
  logic                  use_curve_r;
  logic [17:0]           prod_r;
  logic                  neg_r;
  logic [7:0]            span_r;
  logic [DUTY_W-1:0]     last_duty_r;
  logic                  out_valid_r;
  logic [DUTY_W-1:0]     out_duty_r;
  logic [DEG_W-1:0]      out_temp_r;

  logic              temp_neg;
  logic [TEMP_W-1:0] temp_mag;
  logic [9:0]        deg_quot;
  logic [DIV_NW-1:0] div_num;
  logic [DIV_DW-1:0] div_den;
  logic              div_busy;
  logic              div_done;
  logic [DIV_NW-1:0] div_quot;
  logic [DIV_DW-1:0] div_rem;

  logic [7:0]        sat_pos;
  logic [DEG_W-1:0]  mag9;
  logic [DEG_W-1:0]  t_nxt;

  logic signed [9:0] t_ext;
  logic signed [9:0] lo_s;
  logic signed [9:0] lohy_s;
  logic signed [9:0] hi_s;
  logic [8:0]        lohy;
  logic              le_lo;
  logic              le_lohy;
  logic              ge_hi;
  logic              hold_off;
  logic              need_div;
  logic [DUTY_W-1:0] dec_duty;
  logic [7:0]        dt;
  logic [7:0]        span;
  logic              dneg;
  logic [DUTY_W-1:0] dabs;

  logic [10:0]        qmag;
  logic signed [11:0] q_s;
  logic signed [11:0] sum_s;
  logic [DUTY_W-1:0]  curve_duty;
  logic [DUTY_W-1:0]  fin_duty;
  logic               out_free;

  // degrees from millidegrees: magnitude times reciprocal, then sign and saturate
  always_comb begin
    temp_neg = temp_r[TEMP_W-1];
    temp_mag = temp_neg ? (~temp_r + TEMP_W'(1)) : temp_r;
    deg_quot = deg_prod_r[DEG_SHIFT +: 10];
    sat_pos  = (deg_quot > 10'd255) ? 8'hFF : deg_quot[7:0];
    mag9     = (deg_quot > 10'd256) ? 9'd256 : deg_quot[8:0];
    t_nxt    = temp_neg ? (~mag9 + 9'd1) : {1'b0, sat_pos};
  end

  assign div_num = {1'b0, prod_r};
  assign div_den = {2'b00, span_r};

  fdch_div #(
    .NW (DIV_NW),
    .DW (DIV_DW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  // thresholds and hysteresis
  always_comb begin
    t_ext    = signed'({t_r[DEG_W-1], t_r});
    lo_s     = signed'({2'b00, cfg.temp_lo});
    lohy     = {1'b0, cfg.temp_lo} + {3'b000, cfg.hysteresis};
    lohy_s   = signed'({1'b0, lohy});
    hi_s     = signed'({2'b00, cfg.temp_hi});
    le_lo    = (t_ext <= lo_s);
    le_lohy  = (t_ext <= lohy_s);
    ge_hi    = (t_ext >= hi_s);
    hold_off = le_lohy && (le_lo || (last_duty_r == '0));
    need_div = !ge_hi && !hold_off && cfg.curve_enable;
    if (ge_hi) begin
      dec_duty = cfg.max_duty;
    end else if (hold_off) begin
      dec_duty = '0;
    end else begin
      dec_duty = last_duty_r;
    end
    dt   = t_r[7:0] - cfg.temp_lo;
    span = cfg.temp_hi - cfg.temp_lo;
    dneg = (cfg.max_duty < cfg.min_duty);
    dabs = dneg ? (cfg.min_duty - cfg.max_duty) : (cfg.max_duty - cfg.min_duty);
  end

  // floor quotient, rounded towards minus infinity on a falling curve
  always_comb begin
    qmag  = {1'b0, div_quot[9:0]} + {10'b0, neg_r & (div_rem != '0)};
    q_s   = neg_r ? -signed'({1'b0, qmag}) : signed'({1'b0, qmag});
    sum_s = signed'({2'b00, cfg.min_duty}) + q_s;
    if (sum_s < 0) begin
      curve_duty = '0;
    end else if (sum_s > 12'sd1023) begin
      curve_duty = '1;
    end else begin
      curve_duty = sum_s[DUTY_W-1:0];
    end
    fin_duty = use_curve_r ? curve_duty : dec_duty_r;
    out_free = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      temp_r <= in_temp_milli;
    end
    if (cmd.mul_load) begin
      deg_prod_r <= DEG_PROD_W'(temp_mag) * DEG_PROD_W'(DEG_RECIP);
    end
    if (cmd.t_load) begin
      t_r <= t_nxt;
    end
    if (cmd.dec_load) begin
      dec_duty_r  <= dec_duty;
      use_curve_r <= need_div;
      prod_r      <= 18'(dt) * 18'(dabs);
      neg_r       <= dneg;
      span_r      <= span;
    end
    if (cmd.out_load) begin
      out_duty_r <= fin_duty;
      out_temp_r <= t_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_duty_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        last_duty_r <= fin_duty;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.div_busy = div_busy;
  assign sts.div_done = div_done;
  assign sts.need_div = need_div;
  assign sts.out_free = out_free;

  assign out_valid        = out_valid_r;
  assign out_duty         = out_duty_r;
  assign out_temp_degrees = signed'(out_temp_r);

endmodule

/* rtl/core/fdch_ctrl.sv */
// ----------------------------------------------------------------------------
// fdch_ctrl
// Sequencer: degree conversion, decision, curve division, result hand-off.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fdch_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  fdch_pkg::sts_t sts,
  output fdch_pkg::cmd_t cmd
);

  import fdch_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_TMUL;
      end
      ST_TMUL: state_nxt = ST_TCONV;
      ST_TCONV: state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        state_nxt = sts.need_div ? ST_CSTART : ST_FINISH;
      end
      ST_CSTART: state_nxt = ST_CWAIT;
      ST_CWAIT: begin
        if (sts.div_done) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state_r == ST_IDLE);
    cmd.load_in   = (state_r == ST_IDLE) && in_valid;
    cmd.mul_load  = (state_r == ST_TMUL);
    cmd.div_start = (state_r == ST_CSTART);
    cmd.t_load    = (state_r == ST_TCONV);
    cmd.dec_load  = (state_r == ST_DECIDE);
    cmd.out_load  = (state_r == ST_FINISH) && sts.out_free;
  end

  `FDCH_NEVER(a_start_busy, cmd.div_start && sts.div_busy, "divider restarted while busy")
  `FDCH_ASSERT(a_start_runs, cmd.div_start |=> sts.div_busy, "divider did not start")
  `FDCH_ASSERT(a_load_free, cmd.out_load |-> sts.out_free, "result register overwritten")
  `FDCH_NEVER(a_accept_busy, cmd.load_in && sts.div_busy, "item taken while dividing")

endmodule

/* rtl/core/fan_duty_curve_hysteresis.sv */
// ----------------------------------------------------------------------------
// fan_duty_curve_hysteresis
// Fan duty from a temperature sample: linear curve with turn-on hysteresis.
// ----------------------------------------------------------------------------
// Sequence: an accepted item passes degree conversion and decision; on the
// linear part of the curve one serial division follows before the result is
// loaded and out_valid rises. One item at a time: the next is taken the cycle
// after the result is loaded; a result not yet taken by out_ready holds that load.
// Reset: synchronous active-low; config registers return to defaults, last duty to 0.
module fan_duty_curve_hysteresis (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [fdch_pkg::TEMP_W-1:0]   in_temp_milli,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic        [fdch_pkg::DUTY_W-1:0]   out_duty,
  output logic signed [fdch_pkg::DEG_W-1:0]    out_temp_degrees,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [fdch_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fdch_pkg::CFG_DATA_W-1:0]      cfg_data
);

  import fdch_pkg::*;

  cfg_t cfg_r;
  cmd_t cmd;
  sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.temp_lo      <= 8'd50;
      cfg_r.hysteresis   <= 6'd5;
      cfg_r.temp_hi      <= 8'd70;
      cfg_r.min_duty     <= 10'd20;
      cfg_r.max_duty     <= 10'd100;
      cfg_r.curve_enable <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TEMP_LO:    cfg_r.temp_lo      <= cfg_data[7:0];
        REG_HYSTERESIS: cfg_r.hysteresis   <= cfg_data[5:0];
        REG_TEMP_HI:    cfg_r.temp_hi      <= cfg_data[7:0];
        REG_MIN_DUTY:   cfg_r.min_duty     <= cfg_data;
        REG_MAX_DUTY:   cfg_r.max_duty     <= cfg_data;
        REG_CURVE_EN:   cfg_r.curve_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  fdch_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fdch_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .cmd              (cmd),
    .sts              (sts),
    .in_temp_milli    (in_temp_milli),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_duty         (out_duty),
    .out_temp_degrees (out_temp_degrees)
  );

endmodule
